[hdl/rtttl_pkg.sv]
// rtttl_pkg: shared types and constants for the ringtone parser
// no dependencies
package rtttl_pkg;

   typedef enum logic [3:0] {
      PH_TITLE, PH_HKEY, PH_HEQ, PH_HNUM, PH_HAFTER, PH_NSTART, PH_NDUR,
      PH_SHARP, PH_FLAT, PH_DOT1, PH_OCT, PH_DOT2, PH_SEP, PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      CS_IDLE, CS_DIV, CS_RESULT, CS_EMIT
   } ctl_state_type;

   localparam logic [1:0] ST_NOTE  = 2'd0;
   localparam logic [1:0] ST_END   = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   localparam logic [1:0] CFG_DURATION = 2'd0;
   localparam logic [1:0] CFG_OCTAVE   = 2'd1;
   localparam logic [1:0] CFG_TEMPO    = 2'd2;

   localparam logic [11:0] NUM_64   = 12'd64;
   localparam logic [11:0] NUM_3750 = 12'd3750;
   localparam logic [7:0]  PAUSE    = 8'd48;

   // what the datapath asks of the controller after a beat
   typedef struct packed {
      logic       div_start;   // run the divider
      logic [1:0] n_out;       // results queued for this beat
   } dp_status_type;

   typedef struct packed {
      logic       step;        // apply one input beat
      logic       div_go;      // divider load
      logic       div_done_ack;// write divider result
   } dp_cmd_type;

endpackage

[hdl/rtttl_divider.sv]
// rtttl_divider: restoring divider, one quotient bit per cycle
// depends on rtttl_pkg
module rtttl_divider
   import rtttl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [11:0] numer,
   input  logic [7:0]  denom,
   output logic        busy,
   output logic [7:0]  quotient
);
   logic [11:0] q_ff, q_in;
   logic [8:0]  r_ff, r_in;
   logic [7:0]  d_ff, d_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [8:0]  trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      trial = {r_ff[7:0], q_ff[11]};
      if (start) begin
         q_in = numer;
         r_in = '0;
         d_in = denom;
         cnt_in = 4'd12;
      end else if (cnt_ff != 4'd0) begin
         cnt_in = cnt_ff - 4'd1;
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[10:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[10:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy = (cnt_ff != 4'd0);
   assign quotient = (d_ff == 8'd0) ? 8'd255 : q_ff[7:0];
endmodule

[hdl/rtttl_datapath.sv]
// rtttl_datapath: parse state, header values, pending note and result queue
// depends on rtttl_pkg and rtttl_divider
module rtttl_datapath
   import rtttl_pkg::*;
#(
   parameter int MAX_NOTES = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          div_busy,
   input  logic [7:0]    char_code,
   input  logic          end_of_text,
   input  logic          csr_valid,
   input  logic [1:0]    csr_index,
   input  logic [7:0]    csr_data,
   input  logic          out_sel,
   output logic [1:0]    rsp_status,
   output logic [5:0]    rsp_note,
   output logic [7:0]    rsp_duration,
   output logic [7:0]    rsp_ms_per_64th,
   output logic [9:0]    rsp_note_index,
   output logic          rsp_last
);
   localparam int CW = $clog2(MAX_NOTES + 1);

   phase_type   ph_ff, ph_in;
   logic [7:0]  dd_ff, dd_in, doo_ff, doo_in, dms_ff, dms_in;
   logic [7:0]  cdur_ff, cdur_in, coct_ff, coct_in, cms_ff, cms_in;
   logic [7:0]  acc_ff, acc_in, key_ff, key_in;
   logic [7:0]  pn_ff, pn_in, pd_ff, pd_in, po_ff, po_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   // divider target: 0 none, 1 d, 2 b, 3 note duration
   logic [1:0]  dtgt_ff, dtgt_in;
   logic [11:0] dnum;
   logic        dstart;
   logic [7:0]  quot;
   // two queued results
   logic [1:0]  qst_ff [2], qst_in [2];
   logic [5:0]  qn_ff [2], qn_in [2];
   logic [7:0]  qd_ff [2], qd_in [2];
   logic [9:0]  qi_ff [2], qi_in [2];
   logic        ql_ff [2], ql_in [2];
   logic [1:0]  nout;

   rtttl_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_go), .numer(dnum),
      .denom(acc_ff), .busy(div_busy), .quotient(quot)
   );

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic [7:0] letter(input logic [7:0] c);
      case (c)
         8'h43, 8'h63: return 8'd0;
         8'h44, 8'h64: return 8'd2;
         8'h45, 8'h65: return 8'd4;
         8'h46, 8'h66: return 8'd5;
         8'h47, 8'h67: return 8'd7;
         8'h41, 8'h61: return 8'd9;
         8'h48, 8'h68, 8'h42, 8'h62: return 8'd11;
         default: return PAUSE;
      endcase
   endfunction

   always_comb begin
      logic [7:0] c, nsum;
      logic       endt, run;
      logic [3:0] it;
      logic [CW-1:0] cnt1;
      c = char_code;
      endt = end_of_text || (char_code == 8'd0);
      ph_in = ph_ff; dd_in = dd_ff; doo_in = doo_ff; dms_in = dms_ff;
      cdur_in = cdur_ff; coct_in = coct_ff; cms_in = cms_ff;
      acc_in = acc_ff; key_in = key_ff; pn_in = pn_ff; pd_in = pd_ff;
      po_in = po_ff; cnt_in = cnt_ff; dtgt_in = dtgt_ff;
      qst_in = qst_ff; qn_in = qn_ff; qd_in = qd_ff; qi_in = qi_ff; ql_in = ql_ff;
      nout = 2'd0; dstart = 1'b0; dnum = NUM_64;
      nsum = pn_ff + po_ff;
      cnt1 = cnt_ff + CW'(1);
      if (dtgt_ff == 2'd2) dnum = NUM_3750;

      if (csr_valid) begin
         case (csr_index)
            CFG_DURATION: dd_in = csr_data;
            CFG_OCTAVE:   doo_in = csr_data;
            CFG_TEMPO:    dms_in = csr_data;
            default: ;
         endcase
      end

      if (cmd.div_done_ack) begin
         case (dtgt_ff)
            2'd1: cdur_in = quot;
            2'd2: cms_in = quot;
            2'd3: pd_in = quot;
            default: ;
         endcase
         dtgt_in = 2'd0;
      end

      if (cmd.step) begin
         if (endt) begin
            case (ph_ff)
               PH_TITLE, PH_HKEY, PH_HEQ, PH_HNUM, PH_HAFTER: begin
                  qst_in[0] = ST_ERROR; nout = 2'd1;
               end
               PH_NSTART, PH_NDUR: begin
                  qst_in[0] = ST_END; nout = 2'd1;
               end
               PH_DONE: nout = 2'd0;
               default: begin
                  qst_in[0] = ST_NOTE; nout = 2'd2;
                  qn_in[0] = (nsum > PAUSE) ? 6'd48 : nsum[5:0];
                  qd_in[0] = pd_ff; qi_in[0] = 10'(cnt_ff); ql_in[0] = 1'b0;
                  qst_in[1] = ST_END;
               end
            endcase
            for (int k = 0; k < 2; k++) begin
               if (qst_in[k] != ST_NOTE) begin
                  qn_in[k] = '0; qd_in[k] = '0; qi_in[k] = '0; ql_in[k] = 1'b1;
               end
            end
            ph_in = PH_TITLE; acc_in = '0; key_in = '0; pn_in = '0;
            pd_in = '0; po_in = '0; cnt_in = '0;
         end else begin
            run = 1'b1; it = 4'd0;
            while (run && it < 4'd8) begin
               run = 1'b0; it = it + 4'd1;
               case (ph_in)
                  PH_TITLE: if (c == 8'h3a) begin
                     cdur_in = dd_ff; coct_in = doo_ff; cms_in = dms_ff;
                     ph_in = PH_HKEY;
                  end
                  PH_HKEY: if (c == 8'h3a) ph_in = PH_NSTART;
                     else if (c != 8'h20) begin key_in = c; ph_in = PH_HEQ; end
                  PH_HEQ: if (c != 8'h3d) begin
                        qst_in[0] = ST_ERROR; qn_in[0] = '0; qd_in[0] = '0;
                        qi_in[0] = '0; ql_in[0] = 1'b1; nout = 2'd1; ph_in = PH_DONE;
                     end else begin acc_in = '0; ph_in = PH_HNUM; end
                  PH_HNUM: if (is_dig(c)) acc_in = acc_ff * 8'd10 + (c - 8'h30);
                     else begin
                        if (key_ff == 8'h64) begin dtgt_in = 2'd1; dstart = 1'b1; end
                        else if (key_ff == 8'h6f) coct_in = (acc_ff - 8'd4) * 8'd12;
                        else if (key_ff == 8'h62) begin dtgt_in = 2'd2; dstart = 1'b1; end
                        ph_in = PH_HAFTER; run = 1'b1;
                     end
                  PH_HAFTER: if (c == 8'h2c) ph_in = PH_HKEY;
                     else if (c != 8'h20) begin ph_in = PH_HKEY; run = 1'b1; end
                  PH_NSTART: if (c != 8'h20) begin
                        pd_in = cdur_ff;
                        if (is_dig(c)) begin acc_in = c - 8'h30; ph_in = PH_NDUR; end
                        else begin pn_in = letter(c); po_in = coct_ff; ph_in = PH_SHARP; end
                     end
                  PH_NDUR: if (is_dig(c)) acc_in = acc_ff * 8'd10 + (c - 8'h30);
                     else begin
                        dtgt_in = 2'd3; dstart = 1'b1;
                        pn_in = letter(c); po_in = coct_ff; ph_in = PH_SHARP;
                     end
                  PH_SHARP: begin ph_in = PH_FLAT;
                     if (c == 8'h23) pn_in = pn_ff + 8'd1; else run = 1'b1; end
                  PH_FLAT: begin ph_in = PH_DOT1;
                     if (c == 8'h62) pn_in = pn_ff - 8'd1; else run = 1'b1; end
                  PH_DOT1: begin ph_in = PH_OCT;
                     if (c == 8'h2e) pd_in = pd_ff + {1'b0, pd_ff[7:1]}; else run = 1'b1; end
                  PH_OCT: begin ph_in = PH_DOT2;
                     if (is_dig(c)) po_in = (c - 8'h34) * 8'd12; else run = 1'b1; end
                  PH_DOT2: begin ph_in = PH_SEP;
                     if (c == 8'h2e) pd_in = pd_ff + {1'b0, pd_ff[7:1]}; else run = 1'b1; end
                  PH_SEP: if (c != 8'h20) begin
                        qst_in[0] = ST_NOTE; ql_in[0] = 1'b0;
                        qn_in[0] = (nsum > PAUSE) ? 6'd48 : nsum[5:0];
                        qd_in[0] = pd_ff; qi_in[0] = 10'(cnt_ff);
                        nout = 2'd1; cnt_in = cnt1; ph_in = PH_NSTART;
                        if (32'(cnt1) >= MAX_NOTES) begin
                           qst_in[1] = ST_END; qn_in[1] = '0; qd_in[1] = '0;
                           qi_in[1] = '0; ql_in[1] = 1'b1; nout = 2'd2;
                           ph_in = PH_DONE;
                        end else if (c != 8'h2c) begin
                           // reparse only the start of the next note
                           pd_in = cdur_ff;
                           if (is_dig(c)) begin acc_in = c - 8'h30; ph_in = PH_NDUR; end
                           else begin pn_in = letter(c); po_in = coct_ff; ph_in = PH_SHARP; end
                        end
                     end
                  default: ;
               endcase
            end
         end
      end
      status.div_start = dstart;
      status.n_out = nout;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_TITLE;
         dd_ff <= 8'd16; doo_ff <= 8'd24; dms_ff <= 8'd59;
         cdur_ff <= 8'd16; coct_ff <= 8'd24; cms_ff <= 8'd59;
         acc_ff <= '0; key_ff <= '0; pn_ff <= '0; pd_ff <= '0; po_ff <= '0;
         cnt_ff <= '0; dtgt_ff <= '0;
      end else begin
         ph_ff <= ph_in;
         dd_ff <= dd_in; doo_ff <= doo_in; dms_ff <= dms_in;
         cdur_ff <= cdur_in; coct_ff <= coct_in; cms_ff <= cms_in;
         acc_ff <= acc_in; key_ff <= key_in; pn_ff <= pn_in; pd_ff <= pd_in;
         po_ff <= po_in; cnt_ff <= cnt_in; dtgt_ff <= dtgt_in;
      end
      qst_ff <= qst_in; qn_ff <= qn_in; qd_ff <= qd_in; qi_ff <= qi_in; ql_ff <= ql_in;
   end

   assign rsp_status = qst_ff[out_sel];
   assign rsp_note = qn_ff[out_sel];
   assign rsp_duration = qd_ff[out_sel];
   assign rsp_ms_per_64th = cms_ff;
   assign rsp_note_index = qi_ff[out_sel];
   assign rsp_last = ql_ff[out_sel];
endmodule

[hdl/rtttl_controller.sv]
// rtttl_controller: sequences input beats, divider runs and result beats
// depends on rtttl_pkg
module rtttl_controller
   import rtttl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   input  logic          div_busy,
   output dp_cmd_type    cmd,
   output logic          out_sel
);
   ctl_state_type st_ff, st_in;
   logic [1:0] left_ff, left_in;
   logic       sel_ff, sel_in;
   logic       div_ff, div_in;

   always_comb begin
      st_in = st_ff; left_in = left_ff; sel_in = sel_ff; div_in = div_ff;
      case (st_ff)
         CS_IDLE: if (req_valid) begin
            div_in = status.div_start;
            left_in = status.n_out;
            sel_in = 1'b0;
            st_in = status.div_start ? CS_DIV : (status.n_out != 2'd0 ? CS_EMIT : CS_IDLE);
         end
         CS_DIV: st_in = CS_RESULT;
         CS_RESULT: if (!div_busy) st_in = (left_ff != 2'd0) ? CS_EMIT : CS_IDLE;
         CS_EMIT: if (rsp_ready) begin
            left_in = left_ff - 2'd1;
            sel_in = 1'b1;
            if (left_ff == 2'd1) st_in = CS_IDLE;
         end
         default: st_in = CS_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (st_ff == CS_IDLE);
      rsp_valid = (st_ff == CS_EMIT);
      out_sel = sel_ff;
      cmd.step = (st_ff == CS_IDLE) && req_valid;
      cmd.div_go = (st_ff == CS_DIV);
      cmd.div_done_ack = (st_ff == CS_RESULT) && !div_busy && div_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= CS_IDLE; left_ff <= '0; sel_ff <= 1'b0; div_ff <= 1'b0;
      end else begin
         st_ff <= st_in; left_ff <= left_in; sel_ff <= sel_in; div_ff <= div_in;
      end
   end
endmodule

[hdl/rtttl_ringtone_parser_unit.sv]
// Ringtone text parser. One character beat is taken when the block is idle.
// A plain character leaves the block idle; a beat that closes a d=, b= or note
// duration value runs the shared 12-step divider, and the next beat is taken
// only once it is done; each result beat then waits on rsp_ready. Configuration
// is taken any time.
// depends on rtttl_pkg, rtttl_controller, rtttl_datapath
module rtttl_ringtone_parser_unit
   import rtttl_pkg::*;
#(
   parameter int MAX_NOTES = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_note,
   output logic [7:0] rsp_duration,
   output logic [7:0] rsp_ms_per_64th,
   output logic [9:0] rsp_note_index,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          div_busy, out_sel;

   assign csr_ready = 1'b1;

   rtttl_controller u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status),
      .div_busy(div_busy), .cmd(cmd), .out_sel(out_sel)
   );

   rtttl_datapath #(.MAX_NOTES(MAX_NOTES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status), .div_busy(div_busy),
      .char_code(req_char_code), .end_of_text(req_end_of_text),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .out_sel(out_sel), .rsp_status(rsp_status), .rsp_note(rsp_note),
      .rsp_duration(rsp_duration), .rsp_ms_per_64th(rsp_ms_per_64th),
      .rsp_note_index(rsp_note_index), .rsp_last(rsp_last)
   );
endmodule

[hdl/rtttl_checker.sv]
// rtttl_checker: port-level checks for the ringtone parser
// depends on rtttl_pkg; bound to rtttl_ringtone_parser_unit
module rtttl_checker
   import rtttl_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [5:0] rsp_note,
   input logic       rsp_last
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken during result beat");
   a_note_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_note <= 6'd48) else $error("note out of range");
   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_NOTE |-> rsp_last) else $error("end beat not last");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid) else $error("input beat withdrawn");
endmodule

bind rtttl_ringtone_parser_unit rtttl_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_note(rsp_note), .rsp_last(rsp_last)
);

[bench/rtttl_ringtone_parser_unit_test.sv]
// rtttl_ringtone_parser_unit_test: self-checking bench for the ringtone parser
// drives ringtone texts and noise beats, predicts every record, compares in order
// depends on rtttl_pkg and rtttl_ringtone_parser_unit
`timescale 1ns / 1ps

module rtttl_ringtone_parser_unit_test;
   import rtttl_pkg::*;

   localparam int NOTE_LIMIT = 1024;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [7:0] ch;
      logic       eot;
      bit         drain;
   } text_beat_t;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] note;
      logic [7:0] duration;
      logic [7:0] ms;
      logic [9:0] index;
      logic       last;
   } note_rec_t;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [7:0] req_char_code = 0;
   logic       req_end_of_text = 0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic [1:0] rsp_status;
   logic [5:0] rsp_note;
   logic [7:0] rsp_duration;
   logic [7:0] rsp_ms_per_64th;
   logic [9:0] rsp_note_index;
   logic       rsp_last;
   logic       csr_valid = 0;
   logic       csr_ready;
   logic [1:0] csr_index = 0;
   logic [7:0] csr_data = 0;

   rtttl_ringtone_parser_unit dut (.*);

   initial forever #4 clock = ~clock;

   text_beat_t beat_q[$];
   note_rec_t  note_q[$];
   int         errors = 0;
   int         send_gap = 0;
   int         stall_left = 0;
   bit         calm = 0;
   int         cycles = 0;

   // parser copy
   logic [7:0] cfg_dur = 16, cfg_oct = 24, cfg_tempo = 59;
   phase_type  ph = PH_TITLE;
   logic [7:0] cur_dur = 16, cur_oct = 24, cur_tempo = 59;
   logic [7:0] acc = 0, hkey = 0, pend_note = 0, pend_dur = 0, pend_oct = 0;
   int         notes_out = 0;

   function automatic logic [7:0] quotient_or_max(int num, logic [7:0] den);
      if (den == 0) return 8'd255;
      return 8'((num / den) & 255);
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   task automatic push_rec(logic [1:0] st, logic [7:0] nt, logic [7:0] du, int idx,
                           logic lst);
      note_rec_t r;
      r.status = st; r.note = nt[5:0]; r.duration = du; r.ms = cur_tempo;
      r.index = idx[9:0]; r.last = lst;
      note_q.push_back(r);
   endtask

   task automatic emit_note();
      logic [7:0] n;
      n = pend_note + pend_oct;
      if (n > PAUSE) n = PAUSE;
      push_rec(ST_NOTE, n, pend_dur, notes_out, 0);
      notes_out++;
      if (notes_out >= NOTE_LIMIT) begin
         push_rec(ST_END, 0, 0, 0, 1);
         ph = PH_DONE;
      end
   endtask

   task automatic start_letter(logic [7:0] c);
      case (c)
         "C", "c": pend_note = 0;
         "D", "d": pend_note = 2;
         "E", "e": pend_note = 4;
         "F", "f": pend_note = 5;
         "G", "g": pend_note = 7;
         "A", "a": pend_note = 9;
         "H", "h", "B", "b": pend_note = 11;
         default: pend_note = PAUSE;
      endcase
      pend_oct = cur_oct;
      ph = PH_SHARP;
   endtask

   task automatic rearm();
      ph = PH_TITLE; acc = 0; hkey = 0; pend_note = 0; pend_dur = 0; pend_oct = 0;
      notes_out = 0;
   endtask

   task automatic predict_char(logic [7:0] c);
      bit again;
      again = 1;
      while (again) begin
         again = 0;
         case (ph)
            PH_TITLE: if (c == ":") begin
               cur_dur = cfg_dur; cur_oct = cfg_oct; cur_tempo = cfg_tempo;
               ph = PH_HKEY;
            end
            PH_HKEY: if (c == ":") ph = PH_NSTART;
               else if (c != " ") begin
                  hkey = c; ph = PH_HEQ;
               end
            PH_HEQ: if (c != "=") begin
                  push_rec(ST_ERROR, 0, 0, 0, 1);
                  ph = PH_DONE;
               end else begin
                  acc = 0; ph = PH_HNUM;
               end
            PH_HNUM: if (is_digit(c)) acc = acc * 8'd10 + (c - 8'd48);
               else begin
                  if (hkey == "d") cur_dur = quotient_or_max(64, acc);
                  else if (hkey == "o") cur_oct = (acc - 8'd4) * 8'd12;
                  else if (hkey == "b") cur_tempo = quotient_or_max(3750, acc);
                  ph = PH_HAFTER; again = 1;
               end
            PH_HAFTER: if (c != " ") begin
                  ph = PH_HKEY;
                  again = (c != ",");
               end
            PH_NSTART: if (c != " ") begin
                  pend_dur = cur_dur;
                  if (is_digit(c)) begin
                     acc = c - 8'd48; ph = PH_NDUR;
                  end else start_letter(c);
               end
            PH_NDUR: if (is_digit(c)) acc = acc * 8'd10 + (c - 8'd48);
               else begin
                  pend_dur = quotient_or_max(64, acc);
                  start_letter(c);
               end
            PH_SHARP: begin
               ph = PH_FLAT;
               if (c == "#") pend_note = pend_note + 8'd1; else again = 1;
            end
            PH_FLAT: begin
               ph = PH_DOT1;
               if (c == "b") pend_note = pend_note - 8'd1; else again = 1;
            end
            PH_DOT1, PH_DOT2: begin
               ph = (ph == PH_DOT1) ? PH_OCT : PH_SEP;
               if (c == ".") pend_dur = pend_dur + pend_dur / 8'd2; else again = 1;
            end
            PH_OCT: begin
               ph = PH_DOT2;
               if (is_digit(c)) pend_oct = (c - 8'd48 - 8'd4) * 8'd12; else again = 1;
            end
            PH_SEP: if (c != " ") begin
                  ph = PH_NSTART;
                  emit_note();
                  // unless the note limit was reached, a character that is not a comma starts the next note
                  again = (ph != PH_DONE && c != ",");
               end
            default: ;
         endcase
      end
   endtask

   task automatic predict_end();
      case (ph)
         PH_TITLE, PH_HKEY, PH_HEQ, PH_HNUM, PH_HAFTER: push_rec(ST_ERROR, 0, 0, 0, 1);
         PH_NSTART, PH_NDUR: push_rec(ST_END, 0, 0, 0, 1);
         PH_DONE: ;
         default: begin
            emit_note();
            if (ph != PH_DONE) push_rec(ST_END, 0, 0, 0, 1);
         end
      endcase
      rearm();
   endtask

   // sender
   always @(posedge clock) begin : drive_text
      text_beat_t b;
      if (reset) begin
         req_valid <= 0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_end_of_text || req_char_code == 0) predict_end();
            else predict_char(req_char_code);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 0;
            end else if (beat_q.size() > 0 && !(beat_q[0].drain && note_q.size() > 0)) begin
               b = beat_q.pop_front();
               req_char_code <= b.ch;
               req_end_of_text <= b.eot;
               req_valid <= 1;
               if (!calm && $urandom_range(0, 11) == 0) send_gap <= $urandom_range(1, 10);
            end else req_valid <= 0;
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin : check_records
      note_rec_t e;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (note_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat status %0d note %0d", $time, rsp_status,
                        rsp_note);
            end else begin
               e = note_q.pop_front();
               if (rsp_status !== e.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               end
               if (rsp_note !== e.note) begin
                  errors++;
                  $display("%0t: note expected %0d actual %0d", $time, e.note, rsp_note);
               end
               if (rsp_duration !== e.duration) begin
                  errors++;
                  $display("%0t: duration expected %0d actual %0d", $time, e.duration,
                           rsp_duration);
               end
               if (rsp_ms_per_64th !== e.ms) begin
                  errors++;
                  $display("%0t: ms_per_64th expected %0d actual %0d", $time, e.ms,
                           rsp_ms_per_64th);
               end
               if (rsp_note_index !== e.index) begin
                  errors++;
                  $display("%0t: note_index expected %0d actual %0d", $time, e.index,
                           rsp_note_index);
               end
               if (rsp_last !== e.last) begin
                  errors++;
                  $display("%0t: last expected %0d actual %0d", $time, e.last, rsp_last);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 0;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(1, 10) - 1;
            rsp_ready <= 0;
         end else rsp_ready <= 1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic add(logic [7:0] c, logic e, bit d = 0);
      text_beat_t b;
      b.ch = c; b.eot = e; b.drain = d;
      beat_q.push_back(b);
   endtask

   task automatic add_str(string s);
      for (int i = 0; i < s.len(); i++) add(s[i], 0);
   endtask

   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   task automatic add_digits(int lo, int hi);
      int n;
      n = $urandom_range(lo, hi);
      for (int i = 0; i < n; i++) add(pick("0123456789"), 0);
   endtask

   // one ringtone, mostly well formed
   task automatic add_text();
      int n;
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         logic [7:0] c;
         c = 8'($urandom_range(1, 255));
         if (c == ":") c = "t";
         add(c, 0);
      end
      add(":", 0);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         if (i > 0) add(",", 0);
         if ($urandom_range(0, 3) == 0) add(" ", 0);
         add(pick("dddooobbbx"), 0);
         if ($urandom_range(0, 15) != 0) add("=", 0);
         add_digits(0, 3);
         if ($urandom_range(0, 4) == 0) add(" ", 0);
      end
      if ($urandom_range(0, 15) != 0) add(":", 0);
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         add_digits(0, $urandom_range(0, 4) == 0 ? 3 : 2);
         add(pick("cdefgabhCDEFGABHpx"), 0);
         if ($urandom_range(0, 3) == 0) add("#", 0);
         if ($urandom_range(0, 3) == 0) add("b", 0);
         if ($urandom_range(0, 3) == 0) add(".", 0);
         if ($urandom_range(0, 1) == 0) add(pick("0123456789"), 0);
         if ($urandom_range(0, 3) == 0) add(".", 0);
         case ($urandom_range(0, 5))
            0: add(" ", 0);
            1: add_str(" ,");
            2: ;
            default: add(",", 0);
         endcase
         if ($urandom_range(0, 40) == 0) break;
      end
      if ($urandom_range(0, 3) == 0) add(0, 0);
      else add(8'($urandom_range(0, 255)), 1);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] v);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         CFG_DURATION: cfg_dur = v;
         CFG_OCTAVE: cfg_oct = v;
         default: cfg_tempo = v;
      endcase
   endtask

   task automatic settle();
      while (beat_q.size() > 0 || req_valid || note_q.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      int sent;
      repeat (9) @(posedge clock);
      reset <= 0;
      repeat (2) @(posedge clock);

      // directed texts with reset defaults
      add_str("t:d=0,o=9,b=0,q=7:0c#.4.,2hb, 8p,h");
      add(8'h41, 1);
      add_str("t:d4");
      add(0, 0);
      add_str(":");
      add(0, 0);
      add_str("::32Hb1., 3");
      add(0, 1);
      add(0, 1);
      settle();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               write_csr(CFG_DURATION, 0); write_csr(CFG_OCTAVE, 0);
               write_csr(CFG_TEMPO, 0);
            end
            1: begin
               write_csr(CFG_DURATION, 255); write_csr(CFG_OCTAVE, 255);
               write_csr(CFG_TEMPO, 255);
            end
            default: begin
               write_csr(CFG_DURATION, 8'($urandom_range(0, 255)));
               write_csr(CFG_OCTAVE, 8'($urandom_range(0, 4) * 12));
               write_csr(CFG_TEMPO, 8'($urandom_range(0, 255)));
            end
         endcase
         if (p == 5) calm = 1;
         sent = 0;
         while (sent < 35) begin
            int before_n;
            before_n = beat_q.size();
            if ($urandom_range(0, 9) == 0)
               add(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            else add_text();
            sent += beat_q.size() - before_n;
         end
         // hold the sender until everything so far is out
         add(":", 0, 1);
         add(0, 1);
         if (p == 2) begin
            // long melody that hits the note limit, then trailing text is ignored
            add_str("::");
            for (int i = 0; i < NOTE_LIMIT + 3; i++) add("c", 0);
            add(0, 1);
         end
         settle();
      end

      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

[sim.f]
hdl/rtttl_pkg.sv
hdl/rtttl_divider.sv
hdl/rtttl_datapath.sv
hdl/rtttl_controller.sv
hdl/rtttl_ringtone_parser_unit.sv
hdl/rtttl_checker.sv
bench/rtttl_ringtone_parser_unit_test.sv
